FILE: rtl/multi_servo_sweep_controller_core_defines.svh
// Assertion macros for the servo sweep controller.
// Full checks for simulation; empty bodies when SYNTH is set.
`ifndef MULTI_SERVO_SWEEP_CONTROLLER_CORE_DEFINES_SVH
`define MULTI_SERVO_SWEEP_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTH
`define MSC_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("msc: same-cycle check failed");
`define MSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("msc: next-cycle check failed");
`else
`define MSC_ASSERT_IMPLY(label, ante, cons)
`define MSC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/msc_pkg.sv
package msc_pkg;

	localparam int PULSE_W    = 12;
	localparam int STEP_W     = 7;
	localparam int OP_W       = 4;
	localparam int CH_FIELD_W = 3;
	localparam int MSTEPS_W   = 48;
	localparam int MUL_W      = 20;
	localparam int SHIFT_W    = 16;
	localparam int SUM_W      = 17;

	// divide by 100: (x * DIV100_MUL) >> DIV100_SHIFT, exact for x below 2^19
	localparam int          DIV100_SHIFT = 26;
	localparam logic [19:0] DIV100_MUL   = 20'd671089;

	localparam logic [PULSE_W-1:0] PULSE_RESET      = 12'd1500;
	localparam logic [STEP_W-1:0]  SWEEP_STEP_RESET = 7'd10;
	localparam logic [STEP_W-1:0]  STEP_MIN         = 7'd1;
	localparam logic [STEP_W-1:0]  STEP_MAX         = 7'd100;
	localparam logic [STEP_W-1:0]  SLIDER_FULL      = 7'd100;
	localparam logic [3:0]         SPEED_FAST       = 4'd5;
	localparam logic [3:0]         SPEED_MED        = 4'd2;

	localparam logic [PULSE_W-1:0]  PULSE_MIN_RESET    = 12'd1000;
	localparam logic [PULSE_W-1:0]  PULSE_CENTER_RESET = 12'd1500;
	localparam logic [PULSE_W-1:0]  PULSE_MAX_RESET    = 12'd2000;
	localparam logic [STEP_W-1:0]   STEP_INC_RESET     = 7'd1;
	localparam logic [MSTEPS_W-1:0] MSTEPS_RESET       = 48'd11038234380810;

	// event codes
	localparam logic [OP_W-1:0] OP_TICK       = 4'd0;
	localparam logic [OP_W-1:0] OP_ROTATE     = 4'd1;
	localparam logic [OP_W-1:0] OP_PRESET     = 4'd2;
	localparam logic [OP_W-1:0] OP_SLIDER     = 4'd3;
	localparam logic [OP_W-1:0] OP_TOGGLE     = 4'd4;
	localparam logic [OP_W-1:0] OP_TOGGLE_ALL = 4'd5;
	localparam logic [OP_W-1:0] OP_AUTO       = 4'd6;
	localparam logic [OP_W-1:0] OP_MANUAL     = 4'd7;
	localparam logic [OP_W-1:0] OP_DCLICK     = 4'd8;
	localparam logic [OP_W-1:0] OP_START_STOP = 4'd9;

	// register indexes (byte address = 8 * index)
	localparam logic [2:0] REG_PULSE_MIN    = 3'd0;
	localparam logic [2:0] REG_PULSE_CENTER = 3'd1;
	localparam logic [2:0] REG_PULSE_MAX    = 3'd2;
	localparam logic [2:0] REG_STEP_INC     = 3'd3;
	localparam logic [2:0] REG_MANUAL_STEPS = 3'd4;

	typedef struct packed {
		logic               up;
		logic [PULSE_W-1:0] pulse;
	} chan_entry_t;

	localparam chan_entry_t CHAN_RESET = '{up: 1'b1, pulse: PULSE_RESET};

	// manual base step; channels beyond the sixth have none
	function automatic logic [7:0] manual_base(input logic [MSTEPS_W-1:0] ms,
			input logic [CH_FIELD_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0:    b = ms[7:0];
			3'd1:    b = ms[15:8];
			3'd2:    b = ms[23:16];
			3'd3:    b = ms[31:24];
			3'd4:    b = ms[39:32];
			3'd5:    b = ms[47:40];
			default: b = 8'd0;
		endcase
		return b;
	endfunction

	// low bound wins over high bound
	function automatic logic [PULSE_W-1:0] clamp_pulse(input logic signed [SUM_W-1:0] x,
			input logic [PULSE_W-1:0] lo, input logic [PULSE_W-1:0] hi);
		logic signed [SUM_W-1:0] lo_x;
		logic signed [SUM_W-1:0] hi_x;
		logic [PULSE_W-1:0]      r;
		lo_x = $signed({{(SUM_W-PULSE_W){1'b0}}, lo});
		hi_x = $signed({{(SUM_W-PULSE_W){1'b0}}, hi});
		if (x < lo_x) begin
			r = lo;
		end else if (x > hi_x) begin
			r = hi;
		end else begin
			r = x[PULSE_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/multi_servo_sweep_controller_core.sv
// Each accepted event passes S_CTRL, S_PRIM and S_DISP, then either one status-only record
// (S_STAT) or a walk over the channels from channel 0 that ends at its final record;
// a new event is accepted only in S_IDLE, once the previous one is through.
// The walk takes each channel through a memory read (S_RD) and a read-modify-write (S_WR).
// Output stalls hold S_WR and S_STAT. Reset is asynchronous and clears the control state;
// channel entries read as 1500 us, sweeping up, until first written (no clearing pass).
module multi_servo_sweep_controller_core
	import msc_pkg::*;
#(
	parameter int CHANNELS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	// input event stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // op[3:0], value[15:4], rot_delta[20:16], rot_speed[24:21]
	// record stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // channel[2:0], pulse_us[14:3], enable[15],
	                               // display_pulse[27:16], multi_select[28], auto_on[29],
	                               // sweep_on[30], sweep_step_now[37:31]
	output logic        m_tuser,   // pulse_valid
	output logic        m_tlast,   // final record of the event
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

`include "multi_servo_sweep_controller_core_defines.svh"

	localparam int                CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [CH_W-1:0]   CH_LAST  = CH_W'(CHANNELS - 1);
	localparam logic [CHANNELS-1:0] ALL_MASK = '1;

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;  // waiting for an event
	localparam logic [2:0] S_CTRL = 3'd1;  // flags, mask, step; products
	localparam logic [2:0] S_PRIM = 3'd2;  // read lowest selected channel
	localparam logic [2:0] S_DISP = 3'd3;  // display pulse, slide/rotate offset
	localparam logic [2:0] S_RD   = 3'd4;  // read channel ch_q
	localparam logic [2:0] S_WR   = 3'd5;  // modify, write back, emit record
	localparam logic [2:0] S_STAT = 3'd6;  // status-only record

	// what the channel walk does
	localparam logic [2:0] K_NONE   = 3'd0;
	localparam logic [2:0] K_TICK   = 3'd1;
	localparam logic [2:0] K_SHIFT  = 3'd2;
	localparam logic [2:0] K_PRESET = 3'd3;
	localparam logic [2:0] K_TOGGLE = 3'd4;
	localparam logic [2:0] K_ALL    = 3'd5;

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [PULSE_W-1:0]  pmin_q, pcen_q, pmax_q;
	logic [STEP_W-1:0]   sinc_q;
	logic [MSTEPS_W-1:0] msteps_q;
	logic                cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmin_q   <= PULSE_MIN_RESET;
			pcen_q   <= PULSE_CENTER_RESET;
			pmax_q   <= PULSE_MAX_RESET;
			sinc_q   <= STEP_INC_RESET;
			msteps_q <= MSTEPS_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[5:3])
				REG_PULSE_MIN:    pmin_q   <= pwdata[PULSE_W-1:0];
				REG_PULSE_CENTER: pcen_q   <= pwdata[PULSE_W-1:0];
				REG_PULSE_MAX:    pmax_q   <= pwdata[PULSE_W-1:0];
				REG_STEP_INC:     sinc_q   <= pwdata[STEP_W-1:0];
				REG_MANUAL_STEPS: msteps_q <= pwdata[MSTEPS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[5:3])
			REG_PULSE_MIN:    prdata = 64'(pmin_q);
			REG_PULSE_CENTER: prdata = 64'(pcen_q);
			REG_PULSE_MAX:    prdata = 64'(pmax_q);
			REG_STEP_INC:     prdata = 64'(sinc_q);
			REG_MANUAL_STEPS: prdata = 64'(msteps_q);
			default:          prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// sequencer and control state
	// ---------------------------------------------------------------
	logic [2:0]                 state_q;
	logic [OP_W-1:0]            op_q;
	logic [PULSE_W-1:0]         val_q;
	logic signed [4:0]          delta_q;
	logic [3:0]                 speed_q;
	logic [CHANNELS-1:0]        mask_q;
	logic                       auto_q, run_q;
	logic [STEP_W-1:0]          step_q;
	logic [2:0]                 kind_q;
	logic signed [MUL_W-1:0]    mul_q;     // rotate offset or slider pos*range
	logic [38:0]                prodm_q;   // |pos*range| times reciprocal of 100
	logic signed [SHIFT_W-1:0]  shift_q;
	logic [PULSE_W-1:0]         disp_q;
	logic [CH_W-1:0]            ch_q;
	logic                       first_q;

	// output register
	logic                   m_valid_q;
	logic [CH_FIELD_W-1:0]  o_ch_q;
	logic [PULSE_W-1:0]     o_pulse_q, o_disp_q;
	logic                   o_en_q, o_pv_q, o_multi_q, o_auto_q, o_sweep_q, o_last_q;
	logic [STEP_W-1:0]      o_step_q;

	// channel store
	logic        ram_wr_en, ram_rd_en;
	logic [CH_W-1:0] ram_rd_addr;
	chan_entry_t ram_wr_data, ram_rd_data;

	assign s_tready = (state_q == S_IDLE);

	// lowest selected channel
	logic [CH_W-1:0] prim_idx;
	logic            prim_any;
	logic            multi;

	always_comb begin
		prim_idx = '0;
		for (int i = CHANNELS - 1; i >= 0; i--) begin
			if (mask_q[i]) prim_idx = CH_W'(i);
		end
	end
	assign prim_any = |mask_q;
	assign multi    = |(mask_q & (mask_q - 1'b1));

	// ---- CTRL stage arithmetic ----
	logic [7:0]              base;
	logic [10:0]             st;
	logic signed [16:0]      delta_x, st_x, mv;
	logic [6:0]              pos;
	logic signed [MUL_W-1:0] range_x, pos_x, slide;
	logic signed [11:0]      d12, inc_x, inc_prod;
	logic signed [12:0]      s_new;
	logic [STEP_W-1:0]       s_clamped;
	logic [2:0]              kind_d;

	assign base = manual_base(msteps_q, CH_FIELD_W'(prim_idx));

	always_comb begin
		if (speed_q > SPEED_FAST) begin
			st = (11'(base) << 2) + 11'(base);
		end else if (speed_q > SPEED_MED) begin
			st = 11'(base) << 1;
		end else begin
			st = 11'(base);
		end
	end

	assign delta_x = {{12{delta_q[4]}}, delta_q};
	assign st_x    = $signed({6'b0, st});
	assign mv      = delta_x * st_x;

	assign pos     = (val_q > 12'(SLIDER_FULL)) ? SLIDER_FULL : val_q[6:0];
	assign pos_x   = $signed({13'b0, pos});
	assign range_x = $signed({8'b0, pmax_q}) - $signed({8'b0, pmin_q});
	assign slide   = pos_x * range_x;

	assign d12      = {{7{delta_q[4]}}, delta_q};
	assign inc_x    = $signed({5'b0, sinc_q});
	assign inc_prod = d12 * inc_x;
	assign s_new    = $signed({6'b0, step_q}) + {inc_prod[11], inc_prod};

	always_comb begin
		if (s_new < $signed({6'b0, STEP_MIN})) begin
			s_clamped = STEP_MIN;
		end else if (s_new > $signed({6'b0, STEP_MAX})) begin
			s_clamped = STEP_MAX;
		end else begin
			s_clamped = s_new[STEP_W-1:0];
		end
	end

	always_comb begin
		unique case (op_q)
			OP_TICK:       kind_d = (run_q && auto_q && prim_any) ? K_TICK : K_NONE;
			OP_ROTATE:     kind_d = (!auto_q && !run_q && prim_any) ? K_SHIFT : K_NONE;
			OP_PRESET:     kind_d = prim_any ? K_PRESET : K_NONE;
			OP_SLIDER:     kind_d = prim_any ? K_SHIFT : K_NONE;
			OP_TOGGLE:     kind_d = (val_q < 12'(CHANNELS)) ? K_TOGGLE : K_NONE;
			OP_TOGGLE_ALL: kind_d = K_ALL;
			default:       kind_d = K_NONE;
		endcase
	end

	// ---- PRIM stage: divide by 100 via reciprocal ----
	logic [18:0] mag;
	assign mag = mul_q[MUL_W-1] ? 19'(-mul_q) : mul_q[18:0];

	// ---- DISP stage: slider offset from the primary's current pulse ----
	logic [12:0]               quo;
	logic signed [13:0]        quo_s;
	logic signed [SHIFT_W-1:0] slide_shift;

	assign quo         = prodm_q[DIV100_SHIFT +: 13];
	assign quo_s       = mul_q[MUL_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
	assign slide_shift = $signed({4'b0, pmin_q}) + {{2{quo_s[13]}}, quo_s}
		- $signed({4'b0, ram_rd_data.pulse});

	// ---- WR stage: one channel ----
	logic                    sel, higher_sel, modkind, emit, rec_last, rec_en;
	logic signed [SUM_W-1:0] pw_x, hi_x, lo_x, stepped;
	chan_entry_t             new_ent;
	logic                    out_free, out_load, load_last;

	assign sel     = mask_q[ch_q];
	assign modkind = (kind_q == K_TICK) || (kind_q == K_SHIFT) || (kind_q == K_PRESET);
	assign pw_x    = $signed({5'b0, ram_rd_data.pulse});
	assign hi_x    = $signed({5'b0, pmax_q});
	assign lo_x    = $signed({5'b0, pmin_q});
	assign stepped = ram_rd_data.up ? pw_x + $signed({10'b0, step_q})
	                                : pw_x - $signed({10'b0, step_q});

	always_comb begin
		higher_sel = 1'b0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (mask_q[i] && (i > int'(ch_q))) higher_sel = 1'b1;
		end
	end

	always_comb begin
		new_ent  = ram_rd_data;
		emit     = 1'b0;
		rec_last = 1'b0;
		rec_en   = 1'b1;
		case (kind_q)
			K_TICK: begin
				emit     = sel;
				rec_last = !higher_sel;
				// top bound tested first, bounce reverses direction
				if (stepped >= hi_x) begin
					new_ent.pulse = pmax_q;
					new_ent.up    = 1'b0;
				end else if (stepped <= lo_x) begin
					new_ent.pulse = pmin_q;
					new_ent.up    = 1'b1;
				end else begin
					new_ent.pulse = stepped[PULSE_W-1:0];
				end
			end
			K_SHIFT: begin
				emit          = sel;
				rec_last      = !higher_sel;
				new_ent.pulse = clamp_pulse(pw_x + {shift_q[SHIFT_W-1], shift_q},
					pmin_q, pmax_q);
			end
			K_PRESET: begin
				emit          = sel;
				rec_last      = !higher_sel;
				new_ent.pulse = clamp_pulse($signed({5'b0, val_q}), pmin_q, pmax_q);
			end
			K_TOGGLE: begin
				emit     = (12'(ch_q) == val_q);
				rec_last = 1'b1;
				rec_en   = sel;
			end
			K_ALL: begin
				emit     = 1'b1;
				rec_last = (ch_q == CH_LAST);
				rec_en   = sel;
			end
			default: ;
		endcase
	end

	assign out_free  = !m_valid_q || m_tready;
	assign out_load  = ((state_q == S_WR) && emit || (state_q == S_STAT)) && out_free;
	assign load_last = out_load && ((state_q == S_STAT) || rec_last);

	// write-back only once the record can leave; the walk never reads an entry
	// it has not finished with, so no forwarding is needed
	assign ram_wr_en   = (state_q == S_WR) && emit && modkind && out_free;
	assign ram_wr_data = new_ent;
	assign ram_rd_en   = (state_q == S_PRIM) || (state_q == S_RD);
	assign ram_rd_addr = (state_q == S_PRIM) ? prim_idx : ch_q;

	msc_chan_ram #(
		.DEPTH (CHANNELS),
		.AW    (CH_W)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ram_wr_en),
		.wr_addr (ch_q),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// event payload, products and working values need no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q    <= s_tdata[3:0];
			val_q   <= s_tdata[15:4];
			delta_q <= s_tdata[20:16];
			speed_q <= s_tdata[24:21];
		end
		if (state_q == S_CTRL) begin
			kind_q <= kind_d;
			mul_q  <= (op_q == OP_ROTATE) ? {{(MUL_W-17){mv[16]}}, mv} : slide;
		end
		if (state_q == S_PRIM) begin
			prodm_q <= mag * DIV100_MUL;
		end
		if (state_q == S_DISP) begin
			disp_q  <= prim_any ? ram_rd_data.pulse : pcen_q;
			shift_q <= (op_q == OP_ROTATE) ? mul_q[SHIFT_W-1:0] : slide_shift;
		end
		// display follows the lowest selected channel once it is rewritten
		if (ram_wr_en && first_q) begin
			disp_q <= new_ent.pulse;
		end
		if (out_load) begin
			o_ch_q    <= (state_q == S_WR) ? CH_FIELD_W'(ch_q) : '0;
			o_pulse_q <= (state_q == S_WR) ? new_ent.pulse : '0;
			o_en_q    <= (state_q == S_WR) && rec_en;
			o_pv_q    <= (state_q == S_WR);
			o_disp_q  <= (ram_wr_en && first_q) ? new_ent.pulse : disp_q;
			o_multi_q <= multi;
			o_auto_q  <= auto_q;
			o_sweep_q <= run_q;
			o_step_q  <= step_q;
			o_last_q  <= (state_q == S_STAT) || rec_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			mask_q    <= CHANNELS'(1);
			auto_q    <= 1'b1;
			run_q     <= 1'b0;
			step_q    <= SWEEP_STEP_RESET;
			ch_q      <= '0;
			first_q   <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) state_q <= S_CTRL;
				end
				S_CTRL: begin
					case (op_q)
						OP_ROTATE: begin
							if (auto_q && run_q) step_q <= s_clamped;
						end
						OP_TOGGLE: begin
							if (val_q < 12'(CHANNELS)) begin
								mask_q[val_q[CH_W-1:0]] <= !mask_q[val_q[CH_W-1:0]];
							end
						end
						OP_TOGGLE_ALL: mask_q <= (mask_q == ALL_MASK) ? '0 : ALL_MASK;
						OP_AUTO: begin
							if (!run_q) auto_q <= 1'b1;
						end
						OP_MANUAL: begin
							if (!run_q) auto_q <= 1'b0;
						end
						OP_DCLICK:     auto_q <= 1'b1;
						OP_START_STOP: begin
							if (auto_q) run_q <= !run_q;
						end
						default: ;
					endcase
					state_q <= S_PRIM;
				end
				S_PRIM: state_q <= S_DISP;
				S_DISP: begin
					ch_q    <= '0;
					first_q <= 1'b1;
					state_q <= (kind_q == K_NONE) ? S_STAT : S_RD;
				end
				S_RD: state_q <= S_WR;
				S_WR: begin
					if (!emit || out_free) begin
						if (emit) first_q <= 1'b0;
						if ((emit && rec_last) || (ch_q == CH_LAST)) begin
							state_q <= S_IDLE;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_STAT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b0, o_step_q, o_sweep_q, o_auto_q, o_multi_q, o_disp_q,
	                   o_en_q, o_pulse_q, o_ch_q};
	assign m_tuser  = o_pv_q;
	assign m_tlast  = o_last_q;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	`MSC_ASSERT_IMPLY(a_step_in_range, 1'b1, (step_q >= STEP_MIN) && (step_q <= STEP_MAX))
	`MSC_ASSERT_IMPLY(a_status_beat_is_last, m_tvalid && !m_tuser, m_tlast)
	`MSC_ASSERT_NEXT(a_last_beat_ends_event, load_last, state_q == S_IDLE)

endmodule

FILE: rtl/msc_chan_ram.sv
module msc_chan_ram
	import msc_pkg::*;
#(
	parameter int DEPTH = 6,
	parameter int AW    = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  chan_entry_t   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output chan_entry_t   rd_data
);

	chan_entry_t      mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	chan_entry_t      rd_s1;
	logic             rd_vld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_s1 <= mem_q[rd_addr];
		end
	end

	// per-entry written flags: unwritten entries read as the reset entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_s1 ? rd_s1 : CHAN_RESET;

endmodule
